[hw/rtl/scl_pkg.sv]
`default_nettype none

package scl_pkg;

	// Line buffer sizing: LINE_CAPACITY-1 characters are kept per line
	localparam int LINE_CAPACITY = 32;
	localparam int CHAR_CNT_W    = $clog2(LINE_CAPACITY);

	// Scan position saturates; only the first few positions matter
	localparam int POS_W = 3;

	// Field widths
	localparam int BYTE_W    = 8;
	localparam int CMD_W     = 3;
	localparam int CHAN_W    = 3;
	localparam int US_W      = 12;
	localparam int COUNT_W   = 12;
	localparam int MAXOFF_W  = 9;
	localparam int PERIOD_W  = 16;
	localparam int OFFACC_W  = 10;
	localparam int OUT_DATA_W = 32;

	// Job queue between scanner and converter
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// APB register map
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam logic [1:0] REG_NEUTRAL = 2'd0;
	localparam logic [1:0] REG_MAXOFF  = 2'd1;
	localparam logic [1:0] REG_PERIOD  = 2'd2;

	// Reset values of the configuration registers
	localparam logic [US_W-1:0]     NEUTRAL_RST = 12'd1500;
	localparam logic [MAXOFF_W-1:0] MAXOFF_RST  = 9'd150;
	localparam logic [PERIOD_W-1:0] PERIOD_RST  = 16'd19450;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;
	localparam logic [BYTE_W-1:0] CH_T     = "T";
	localparam logic [BYTE_W-1:0] CH_0     = "0";
	localparam logic [BYTE_W-1:0] CH_7     = "7";
	localparam logic [BYTE_W-1:0] CH_9     = "9";
	localparam logic [BYTE_W-1:0] CH_PLUS  = "+";
	localparam logic [BYTE_W-1:0] CH_MINUS = "-";

	// Offset accumulator clamp
	localparam logic [OFFACC_W-1:0] OFFACC_MAX = 10'd1023;

	// Count conversion: twelve quotient bits, one per step
	localparam int DIV_STEPS  = COUNT_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;
	localparam logic [US_W-1:0]    US_MAX    = 12'd4095;

	typedef enum logic [CMD_W-1:0] {
		CMD_HELP    = 3'd0,
		CMD_NEU     = 3'd1,
		CMD_IMU     = 3'd2,
		CMD_DEPTH   = 3'd3,
		CMD_SENS    = 3'd4,
		CMD_PULSE   = 3'd5,
		CMD_UNKNOWN = 3'd6
	} cmd_t;

	// Keywords, left justified and zero padded to eight characters
	localparam int KW_COUNT = 5;
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		{"HELP", 32'h0},
		{"NEU", 40'h0},
		{"IMU", 40'h0},
		{"DEPTH", 24'h0},
		{"SENS", 32'h0}
	};
	localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd4};

	// Character of keyword k at position p, zero past its end
	function automatic logic [BYTE_W-1:0] kw_char(input int k, input logic [POS_W-1:0] p);
		logic [63:0] s;
		s = KW_TEXT[k];
		return s[(7 - int'(p)) * 8 +: 8];
	endfunction

	// One decoded line handed from scanner to converter
	typedef struct packed {
		cmd_t                cmd;
		logic [CHAN_W-1:0]   chan;
		logic                neg;
		logic [OFFACC_W-1:0] off;
	} job_t;

endpackage

`default_nettype wire

[hw/rtl/scl_front.sv]
`default_nettype none

module scl_front import scl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic              q_full,
	output logic                   q_push,
	output job_t                   q_job
);

	logic [CHAR_CNT_W-1:0] char_cnt_q;
	logic [POS_W-1:0]      text_len_q;
	logic [KW_COUNT-1:0]   kw_flags_q;
	logic                  syntax_ok_q;
	logic [CHAN_W-1:0]     chan_q;
	logic                  neg_q;
	logic [OFFACC_W-1:0]   acc_q;
	logic                  nul_seen_q;

	logic              accept;
	logic              is_eol;
	logic              is_digit;
	logic [13:0]       acc_next;
	logic [KW_COUNT-1:0] kw_next;
	cmd_t              cmd_sel;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_eol   = (in_byte == CH_CR) || (in_byte == CH_LF);
	assign is_digit = (in_byte >= CH_0) && (in_byte <= CH_9);

	// acc*10 + digit, clamped later
	assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ {6'd0, in_byte - CH_0};

	// Keyword candidates that survive this character
	always_comb begin
		for (int k = 0; k < KW_COUNT; k++) begin
			kw_next[k] = kw_flags_q[k] && (in_byte == kw_char(k, text_len_q));
		end
	end

	// First keyword whose full text matched, else a pulse command if the T<chan><sign> syntax held
	always_comb begin
		cmd_sel = CMD_UNKNOWN;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (kw_flags_q[k] && (text_len_q == KW_LEN[k])) begin
				cmd_sel = cmd_t'(k[CMD_W-1:0]);
			end
		end
		if (cmd_sel == CMD_UNKNOWN && syntax_ok_q && text_len_q >= 3'd4) begin
			cmd_sel = CMD_PULSE;
		end
	end

	// Job record at line end
	assign q_push       = accept && is_eol && (char_cnt_q != '0);
	assign q_job.cmd    = cmd_sel;
	assign q_job.chan   = (cmd_sel == CMD_PULSE) ? chan_q : '0;
	assign q_job.neg    = neg_q;
	assign q_job.off    = acc_q;

	// Line scanner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_cnt_q  <= '0;
			text_len_q  <= '0;
			kw_flags_q  <= '1;
			syntax_ok_q <= 1'b1;
			chan_q      <= '0;
			neg_q       <= 1'b0;
			acc_q       <= '0;
			nul_seen_q  <= 1'b0;
		end else if (accept) begin
			if (is_eol) begin
				char_cnt_q  <= '0;
				text_len_q  <= '0;
				kw_flags_q  <= '1;
				syntax_ok_q <= 1'b1;
				chan_q      <= '0;
				neg_q       <= 1'b0;
				acc_q       <= '0;
				nul_seen_q  <= 1'b0;
			end else if (char_cnt_q < CHAR_CNT_W'(LINE_CAPACITY - 1)) begin
				char_cnt_q <= char_cnt_q + 1'b1;
				if (in_byte == CH_NUL) begin
					nul_seen_q <= 1'b1;
				end else if (!nul_seen_q) begin
					kw_flags_q <= kw_next;
					if (text_len_q != '1) begin
						text_len_q <= text_len_q + 1'b1;
					end
					case (text_len_q)
						3'd0: begin
							if (in_byte != CH_T) syntax_ok_q <= 1'b0;
						end
						3'd1: begin
							if (in_byte >= CH_0 && in_byte <= CH_7) begin
								chan_q <= in_byte[CHAN_W-1:0];
							end else begin
								syntax_ok_q <= 1'b0;
							end
						end
						3'd2: begin
							if (in_byte == CH_PLUS) begin
								neg_q <= 1'b0;
							end else if (in_byte == CH_MINUS) begin
								neg_q <= 1'b1;
							end else begin
								syntax_ok_q <= 1'b0;
							end
						end
						default: begin
							if (is_digit) begin
								acc_q <= (acc_next > 14'(OFFACC_MAX)) ? OFFACC_MAX
									: acc_next[OFFACC_W-1:0];
							end else begin
								syntax_ok_q <= 1'b0;
							end
						end
					endcase
				end
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/scl_queue.sv]
`default_nettype none

module scl_queue import scl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output logic      not_empty,
	output job_t      head
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/scl_back.sv]
`default_nettype none

module scl_back import scl_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [US_W-1:0]     neutral_us,
	input  wire logic [MAXOFF_W-1:0] max_offset_us,
	input  wire logic [PERIOD_W-1:0] period_us,
	input  wire logic                q_valid,
	input  wire job_t                q_job,
	output logic                     q_pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [OUT_DATA_W-1:0]    out_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t               state_q;
	cmd_t                 cmd_q;
	logic [CHAN_W-1:0]    chan_q;
	logic [US_W-1:0]      pulse_q;
	logic [COUNT_W-1:0]   quot_q;
	logic [PERIOD_W-1:0]  rem_q;
	logic [COUNT_W-1:0]   low_q;
	logic [DIV_CNT_W-1:0] step_q;

	logic [OFFACC_W-1:0] off_sat;
	logic [12:0]         target;
	logic [US_W-1:0]     band_lo;
	logic [12:0]         band_hi;
	logic [12:0]         clamped;
	logic [US_W-1:0]     pulse_new;
	logic [24:0]         num;
	logic [27:0]         limit;
	logic [16:0]         rem_sh;
	logic [16:0]         rem_diff;

	// Target pulse: offset clamp, neutral +/- offset, safe band, 12-bit cap; neutral for other commands
	always_comb begin
		off_sat = (q_job.off > {1'b0, max_offset_us}) ? {1'b0, max_offset_us} : q_job.off;
		if (q_job.neg) begin
			target = ({1'b0, neutral_us} >= {3'b000, off_sat})
				? {1'b0, neutral_us} - {3'b000, off_sat} : '0;
		end else begin
			target = {1'b0, neutral_us} + {3'b000, off_sat};
		end
		band_lo = (neutral_us >= {3'b000, max_offset_us})
			? neutral_us - {3'b000, max_offset_us} : '0;
		band_hi = {1'b0, neutral_us} + {4'b0000, max_offset_us};
		clamped = target;
		if (clamped < {1'b0, band_lo}) clamped = {1'b0, band_lo};
		if (clamped > band_hi) clamped = band_hi;
		if (q_job.cmd == CMD_PULSE) begin
			pulse_new = clamped[12] ? US_MAX : clamped[US_W-1:0];
		end else begin
			pulse_new = neutral_us;
		end
	end

	// Rounded dividend and overflow bound for the count
	assign num      = {1'b0, pulse_q, 12'h000} + {10'd0, period_us[PERIOD_W-1:1]};
	assign limit    = {period_us, 12'h000};
	assign rem_sh   = {rem_q, low_q[COUNT_W-1]};
	assign rem_diff = rem_sh - {1'b0, period_us};

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = {{(OUT_DATA_W - CMD_W - CHAN_W - US_W - COUNT_W){1'b0}},
		quot_q, pulse_q, chan_q, cmd_q};

	// Conversion sequencer: load, bound check, restoring divide, hold result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			cmd_q   <= CMD_UNKNOWN;
			chan_q  <= '0;
			pulse_q <= '0;
			quot_q  <= '0;
			rem_q   <= '0;
			low_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cmd_q   <= q_job.cmd;
						chan_q  <= q_job.chan;
						pulse_q <= pulse_new;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if ({3'b000, num} >= limit) begin
						quot_q  <= COUNT_MAX;
						state_q <= ST_OUT;
					end else begin
						rem_q   <= {3'b000, num[24:12]};
						low_q   <= num[11:0];
						quot_q  <= '0;
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!rem_diff[16]) begin
						rem_q  <= rem_diff[PERIOD_W-1:0];
						quot_q <= {quot_q[COUNT_W-2:0], 1'b1};
					end else begin
						rem_q  <= rem_sh[PERIOD_W-1:0];
						quot_q <= {quot_q[COUNT_W-2:0], 1'b0};
					end
					low_q  <= {low_q[COUNT_W-2:0], 1'b0};
					step_q <= step_q + 1'b1;
					if (step_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/servo_command_line_decoder.sv]
`default_nettype none

// Channel   Dir  Width  Contents
// s_axis    in   8      rx_byte
// m_axis    out  32     command, channel, pulse_us, pulse_count
// apb       in   4/32   neutral_us @0x0, max_offset_us @0x4, period_us @0x8
//
// Bytes are taken one per cycle while the two-entry line queue has room.
// A line end starts a conversion: one load, one bound check,
// twelve steps of the restoring divider by period_us, then the result is held.
// A count that saturates skips the divider and is offered straight after the bound check.
// Further lines queue up; the scanner stalls only when both entries are full.
// arst_n clears the scanner, queue and sequencer and loads the register defaults.

module servo_command_line_decoder import scl_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,  // [7:0] rx_byte
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [2:0] command, [5:3] channel, [17:6] pulse_us, [29:18] pulse_count
	output logic [OUT_DATA_W-1:0]      m_tdata,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	logic [US_W-1:0]     neutral_q;
	logic [MAXOFF_W-1:0] maxoff_q;
	logic [PERIOD_W-1:0] period_q;
	logic                cfg_wr;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_not_empty;
	job_t push_job;
	job_t head_job;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neutral_q <= NEUTRAL_RST;
			maxoff_q  <= MAXOFF_RST;
			period_q  <= PERIOD_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_NEUTRAL: neutral_q <= pwdata[US_W-1:0];
				REG_MAXOFF:  maxoff_q  <= pwdata[MAXOFF_W-1:0];
				REG_PERIOD:  period_q  <= pwdata[PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (paddr[3:2])
			REG_NEUTRAL: prdata = {{(APB_DATA_W - US_W){1'b0}}, neutral_q};
			REG_MAXOFF:  prdata = {{(APB_DATA_W - MAXOFF_W){1'b0}}, maxoff_q};
			REG_PERIOD:  prdata = {{(APB_DATA_W - PERIOD_W){1'b0}}, period_q};
			default:     prdata = '0;
		endcase
	end

	scl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	scl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_job)
	);

	scl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.neutral_us    (neutral_q),
		.max_offset_us (maxoff_q),
		.period_us     (period_q),
		.q_valid       (q_not_empty),
		.q_job         (head_job),
		.q_pop         (q_pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_data      (m_tdata)
	);

endmodule

`default_nettype wire

[tb/tb_servo_command_line_decoder.sv]
`timescale 1ns / 1ps

module tb_servo_command_line_decoder;
	import scl_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_BYTES   = 145;
	localparam int N_FIXED_SETS  = 8;
	localparam int N_RANDOM_SETS = 2;

	// One decoded line as the block should report it
	typedef struct packed {
		cmd_t               cmd;
		logic [CHAN_W-1:0]  chan;
		logic [US_W-1:0]    pulse;
		logic [COUNT_W-1:0] count;
	} line_result_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata  = '0;   // [7:0] rx_byte
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [2:0] command, [5:3] channel, [17:6] pulse_us, [29:18] pulse_count
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	servo_command_line_decoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Register settings: extremes, out-of-range values, then random ones
	int unsigned set_neutral [N_FIXED_SETS] = '{500, 2500, 1500, 100, 4000, 1234, 4095, 0};
	int unsigned set_maxoff  [N_FIXED_SETS] = '{0, 500, 500, 500, 500, 511, 511, 300};
	int unsigned set_period  [N_FIXED_SETS] = '{2500, 65535, 2500, 3000, 5000, 0, 1, 65535};

	// Keyword table of the decoder
	string kw_word [KW_COUNT] = '{"HELP", "NEU", "IMU", "DEPTH", "SENS"};
	cmd_t  kw_cmd  [KW_COUNT] = '{CMD_HELP, CMD_NEU, CMD_IMU, CMD_DEPTH, CMD_SENS};

	// Shadow copy of the registers
	logic [US_W-1:0]     cfg_neutral = NEUTRAL_RST;
	logic [MAXOFF_W-1:0] cfg_maxoff  = MAXOFF_RST;
	logic [PERIOD_W-1:0] cfg_period  = PERIOD_RST;

	// Line scanner state
	int unsigned         line_chars = 0;
	int unsigned         txt_len    = 0;
	logic [KW_COUNT-1:0] kw_alive   = '1;
	logic                syn_ok     = 1'b1;
	logic [CHAN_W-1:0]   test_chan  = '0;
	logic                neg_off    = 1'b0;
	int unsigned         acc        = 0;
	logic                nul_hit    = 1'b0;

	logic [BYTE_W-1:0] rx_backlog [$];
	line_result_t      decoded_due [$];
	line_result_t      want;

	int fail_cnt      = 0;
	int bytes_sent    = 0;
	int lines_checked = 0;
	int cycle_cnt     = 0;
	int cmd_tally [8] = '{default: 0};
	int burst_left    = 0;
	int gap_left      = 0;
	int ready_mode    = 0;
	int ready_span    = 0;
	int stall_left    = 0;

	// Clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void clear_line_state();
		line_chars = 0;
		txt_len    = 0;
		kw_alive   = '1;
		syn_ok     = 1'b1;
		test_chan  = '0;
		neg_off    = 1'b0;
		acc        = 0;
		nul_hit    = 1'b0;
	endfunction

	// Follow one kept character through keyword flags and pulse syntax
	function automatic void scan_text_char(input logic [BYTE_W-1:0] c);
		int unsigned p;
		int unsigned v;
		int k;
		p = txt_len;
		if (c == CH_NUL) begin
			nul_hit = 1'b1;
			return;
		end
		for (k = 0; k < KW_COUNT; k++) begin
			if (kw_alive[k] && (p >= kw_word[k].len() || c != kw_word[k][p]))
				kw_alive[k] = 1'b0;
		end
		if (p == 0) begin
			if (c != CH_T)
				syn_ok = 1'b0;
		end else if (p == 1) begin
			if (c >= CH_0 && c <= CH_7)
				test_chan = CHAN_W'(c - CH_0);
			else
				syn_ok = 1'b0;
		end else if (p == 2) begin
			if (c == CH_PLUS)
				neg_off = 1'b0;
			else if (c == CH_MINUS)
				neg_off = 1'b1;
			else
				syn_ok = 1'b0;
		end else begin
			if (c >= CH_0 && c <= CH_9) begin
				v = acc * 10 + 32'(c - CH_0);
				acc = (v > OFFACC_MAX) ? OFFACC_MAX : v;
			end else
				syn_ok = 1'b0;
		end
		txt_len = p + 1;
	endfunction

	// Accepted byte: extend the line, or classify it at CR/LF
	function automatic void decode_rx_byte(input logic [BYTE_W-1:0] c);
		int unsigned off, lo, hi, tgt, pulse, cnt;
		cmd_t cmd;
		logic [CHAN_W-1:0] chan;
		line_result_t res;
		bit hit;
		int k;
		if (c == CH_CR || c == CH_LF) begin
			if (line_chars == 0)
				return;
			cmd = CMD_UNKNOWN;
			chan = '0;
			pulse = cfg_neutral;
			hit = 1'b0;
			for (k = 0; k < KW_COUNT; k++) begin
				if (!hit && kw_alive[k] && txt_len == kw_word[k].len()) begin
					cmd = kw_cmd[k];
					hit = 1'b1;
				end
			end
			if (!hit && syn_ok && txt_len >= 4) begin
				off = acc;
				if (off > cfg_maxoff)
					off = cfg_maxoff;
				if (neg_off)
					tgt = (cfg_neutral >= off) ? cfg_neutral - off : 0;
				else
					tgt = cfg_neutral + off;
				lo = (cfg_neutral >= cfg_maxoff) ? cfg_neutral - cfg_maxoff : 0;
				hi = cfg_neutral + cfg_maxoff;
				if (tgt < lo)
					tgt = lo;
				if (tgt > hi)
					tgt = hi;
				cmd = CMD_PULSE;
				chan = test_chan;
				pulse = tgt;
			end
			if (pulse > US_MAX)
				pulse = US_MAX;
			// rounded division by the period, saturating
			if (cfg_period == 0)
				cnt = COUNT_MAX;
			else begin
				cnt = (pulse * 4096 + (32'(cfg_period) >> 1)) / cfg_period;
				if (cnt > COUNT_MAX)
					cnt = COUNT_MAX;
			end
			res.cmd = cmd;
			res.chan = chan;
			res.pulse = US_W'(pulse);
			res.count = COUNT_W'(cnt);
			decoded_due.push_back(res);
			clear_line_state();
		end else if (line_chars < LINE_CAPACITY - 1) begin
			if (!nul_hit)
				scan_text_char(c);
			line_chars++;
		end
	endfunction

	// Stimulus builders
	function automatic logic [BYTE_W-1:0] rand_printable();
		return BYTE_W'($urandom_range(32, 126));
	endfunction

	function automatic void queue_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			rx_backlog.push_back(s[i]);
	endfunction

	function automatic void queue_digits(input int n);
		int i;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 29) == 0)
				rx_backlog.push_back(rand_printable());
			else
				rx_backlog.push_back(BYTE_W'(CH_0 + $urandom_range(0, 9)));
		end
	endfunction

	// T<chan><sign>, mostly well formed
	function automatic void queue_pulse_head();
		rx_backlog.push_back(($urandom_range(0, 15) == 0) ? rand_printable() : CH_T);
		if ($urandom_range(0, 15) < 14)
			rx_backlog.push_back(BYTE_W'(CH_0 + $urandom_range(0, 7)));
		else
			rx_backlog.push_back(rand_printable());
		if ($urandom_range(0, 15) < 14)
			rx_backlog.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
		else
			rx_backlog.push_back(rand_printable());
	endfunction

	function automatic void queue_random_line();
		int kind, n, i, mut, pos, r;
		string w;
		kind = $urandom_range(0, 99);
		w = kw_word[$urandom_range(0, KW_COUNT - 1)];
		n = w.len();
		if (kind < 25) begin
			// keyword, sometimes truncated, extended or with one char changed
			mut = $urandom_range(0, 7);
			pos = $urandom_range(0, n - 1);
			for (i = 0; i < n; i++) begin
				if (!(mut == 0 && i == n - 1)) begin
					if (mut == 2 && i == pos)
						rx_backlog.push_back(rand_printable());
					else
						rx_backlog.push_back(w[i]);
				end
			end
			if (mut == 1)
				rx_backlog.push_back(rand_printable());
		end else if (kind < 60) begin
			queue_pulse_head();
			r = $urandom_range(0, 9);
			if (r == 0)
				n = 0;
			else if (r == 1)
				n = $urandom_range(5, 30);
			else
				n = $urandom_range(1, 4);
			queue_digits(n);
		end else if (kind < 70) begin
			n = $urandom_range(1, 12);
			for (i = 0; i < n; i++)
				rx_backlog.push_back(BYTE_W'($urandom_range(0, 255)));
		end else if (kind < 78) begin
			// near or past the line capacity
			if ($urandom_range(0, 1)) begin
				queue_pulse_head();
				queue_digits($urandom_range(26, 42));
			end else begin
				n = $urandom_range(28, 45);
				for (i = 0; i < n; i++)
					rx_backlog.push_back(rand_printable());
			end
		end else if (kind < 86) begin
			// zero byte inside the line
			n = $urandom_range(0, n);
			for (i = 0; i < n; i++)
				rx_backlog.push_back(w[i]);
			if ($urandom_range(0, 2) == 0)
				queue_pulse_head();
			rx_backlog.push_back(CH_NUL);
			n = $urandom_range(0, 5);
			for (i = 0; i < n; i++)
				rx_backlog.push_back(rand_printable());
		end else if (kind < 93) begin
			// empty line: terminator only
		end else begin
			// lower case or doubled last letter
			if ($urandom_range(0, 1)) begin
				for (i = 0; i < n; i++)
					rx_backlog.push_back(BYTE_W'(w[i] + 8'd32));
			end else begin
				queue_text(w);
				rx_backlog.push_back(w[n - 1]);
			end
		end
		r = $urandom_range(0, 5);
		if (r < 2)
			rx_backlog.push_back(CH_CR);
		else if (r < 4)
			rx_backlog.push_back(CH_LF);
		else if (r == 4) begin
			rx_backlog.push_back(CH_CR);
			rx_backlog.push_back(CH_LF);
		end else begin
			rx_backlog.push_back(CH_LF);
			rx_backlog.push_back(CH_CR);
		end
	endfunction

	// APB write with readback of the register
	task automatic program_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_NEUTRAL: cfg_neutral = value[US_W-1:0];
			REG_MAXOFF:  cfg_maxoff  = value[MAXOFF_W-1:0];
			REG_PERIOD:  cfg_period  = value[PERIOD_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== value) begin
			$error("register %0d readback: expected %0d, got %0d", idx, value, prdata);
			fail_cnt++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_settings(input int unsigned neu, input int unsigned mo,
			input int unsigned per);
		program_reg(REG_NEUTRAL, APB_DATA_W'(neu));
		program_reg(REG_MAXOFF, APB_DATA_W'(mo));
		program_reg(REG_PERIOD, APB_DATA_W'(per));
	endtask

	// Hold off until every byte is taken and every line reported
	task automatic wait_drained();
		do
			@(negedge clk);
		while (rx_backlog.size() != 0 || s_tvalid || decoded_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Byte driver: bursts of random length with random gaps
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			decode_rx_byte(s_tdata);
			bytes_sent++;
		end
		if (!s_tvalid || s_tready) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (rx_backlog.size() > 0) begin
				s_tdata  <= rx_backlog.pop_front();
				s_tvalid <= 1'b1;
				if (burst_left > 0)
					burst_left--;
				else begin
					burst_left = $urandom_range(0, 24);
					case ($urandom_range(0, 3))
						0: gap_left = 0;
						1: gap_left = $urandom_range(1, 3);
						2: gap_left = $urandom_range(4, 20);
						default: gap_left = $urandom_range(15, 45);
					endcase
				end
			end else
				s_tvalid <= 1'b0;
		end
	end

	// Result receiver: always ready, random, or long stalls
	always @(posedge clk) begin
		if (ready_span == 0) begin
			ready_mode = $urandom_range(0, 2);
			ready_span = $urandom_range(20, 200);
		end else
			ready_span--;
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (ready_mode == 1)
			m_tready <= 1'($urandom_range(0, 1));
		else if (ready_mode == 2 && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 30);
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	// Result checker
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (decoded_due.size() == 0) begin
				$error("result with no line pending: m_tdata=%h", m_tdata);
				fail_cnt++;
			end else begin
				want = decoded_due.pop_front();
				lines_checked++;
				cmd_tally[m_tdata[2:0]]++;
				if (m_tdata[2:0] !== want.cmd) begin
					$error("command: expected %0d, got %0d", want.cmd, m_tdata[2:0]);
					fail_cnt++;
				end
				if (m_tdata[5:3] !== want.chan) begin
					$error("channel: expected %0d, got %0d", want.chan, m_tdata[5:3]);
					fail_cnt++;
				end
				if (m_tdata[17:6] !== want.pulse) begin
					$error("pulse_us: expected %0d, got %0d", want.pulse, m_tdata[17:6]);
					fail_cnt++;
				end
				if (m_tdata[29:18] !== want.count) begin
					$error("pulse_count: expected %0d, got %0d", want.count,
						m_tdata[29:18]);
					fail_cnt++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Sequence: directed and random lines at reset settings, then random lines under each setting
	initial begin
		int ph;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		@(negedge clk);
		queue_text("HELP");
		rx_backlog.push_back(CH_CR);
		queue_text("NEU");
		rx_backlog.push_back(CH_LF);
		queue_text("IMU");
		rx_backlog.push_back(CH_CR);
		rx_backlog.push_back(CH_LF);
		queue_text("DEPTH");
		rx_backlog.push_back(CH_CR);
		queue_text("SENS");
		rx_backlog.push_back(CH_LF);
		// digit string past the accumulator clamp
		queue_text("T7-9999");
		rx_backlog.push_back(CH_CR);
		// line of only a zero byte still decodes
		rx_backlog.push_back(CH_NUL);
		rx_backlog.push_back(CH_CR);
		while (rx_backlog.size() < PHASE_BYTES)
			queue_random_line();
		wait_drained();

		for (ph = 0; ph < N_FIXED_SETS + N_RANDOM_SETS; ph++) begin
			if (ph < N_FIXED_SETS)
				apply_settings(set_neutral[ph], set_maxoff[ph], set_period[ph]);
			else
				apply_settings($urandom_range(500, 2500), $urandom_range(0, 500),
					$urandom_range(2500, 65535));
			@(negedge clk);
			while (rx_backlog.size() < PHASE_BYTES)
				queue_random_line();
			wait_drained();
		end

		if (decoded_due.size() != 0) begin
			$error("%0d decoded lines never reported", decoded_due.size());
			fail_cnt++;
		end
		$display("Sent %0d bytes, checked %0d decoded lines over %0d register settings.",
			bytes_sent, lines_checked, N_FIXED_SETS + N_RANDOM_SETS + 1);
		$display("By command: help %0d neu %0d imu %0d depth %0d sens %0d pulse %0d unknown %0d",
			cmd_tally[CMD_HELP], cmd_tally[CMD_NEU], cmd_tally[CMD_IMU],
			cmd_tally[CMD_DEPTH], cmd_tally[CMD_SENS], cmd_tally[CMD_PULSE],
			cmd_tally[CMD_UNKNOWN]);
		if (fail_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
